@@ design/mrwt_pkg.sv @@
package mrwt_pkg;

  typedef struct packed {
    logic round_composite;
    logic verdict_composite;
    logic bad_input;
    logic verdict_final;
  } mrwt_result_t;

endpackage

@@ design/mrwt_if.sv @@
interface mrwt_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] candidate;
  logic [31:0] base;
  logic        last_round;
  modport source (output valid, candidate, base, last_round, input ready);
  modport sink (input valid, candidate, base, last_round, output ready);
endinterface

interface mrwt_out_if;
  logic valid;
  logic ready;
  logic round_composite;
  logic verdict_composite;
  logic bad_input;
  logic verdict_final;
  modport source (output valid, round_composite, verdict_composite, bad_input,
                  verdict_final, input ready);
  modport sink (input valid, round_composite, verdict_composite, bad_input,
                verdict_final, output ready);
endinterface

@@ design/mrwt_mulmod.sv @@
module mrwt_mulmod import mrwt_pkg::*; #(
  parameter int NUM_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [NUM_WIDTH-1:0] x,
  input  logic [NUM_WIDTH-1:0] y,
  input  logic [NUM_WIDTH-1:0] m,
  output logic                 done,
  output logic [NUM_WIDTH-1:0] p
);

  localparam int CW = $clog2(NUM_WIDTH + 1);

  logic [NUM_WIDTH-1:0] ysh;
  logic [CW-1:0]        cnt;
  logic                 busy;
  logic [NUM_WIDTH:0]   dbl;
  logic [NUM_WIDTH-1:0] dbl_r;
  logic [NUM_WIDTH:0]   sum;
  logic [NUM_WIDTH-1:0] acc_next;

  // One bit of the multiplier per cycle, most significant first.
  always_comb begin
    dbl   = {p, 1'b0};
    dbl_r = (dbl >= {1'b0, m}) ? NUM_WIDTH'(dbl - {1'b0, m}) : dbl[NUM_WIDTH-1:0];
    sum   = {1'b0, dbl_r} + {1'b0, x};
    if (ysh[NUM_WIDTH-1]) begin
      acc_next = (sum >= {1'b0, m}) ? NUM_WIDTH'(sum - {1'b0, m}) : sum[NUM_WIDTH-1:0];
    end else begin
      acc_next = dbl_r;
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      p    <= '0;
      ysh  <= y;
      cnt  <= CW'(NUM_WIDTH);
    end else if (busy) begin
      p   <= acc_next;
      ysh <= {ysh[NUM_WIDTH-2:0], 1'b0};
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

@@ design/mrwt_ctrl.sv @@
module mrwt_ctrl import mrwt_pkg::*; #(
  parameter int NUM_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 go,
  input  logic [NUM_WIDTH-1:0] n,
  input  logic [NUM_WIDTH-1:0] a,
  output logic                 fin,
  output logic                 comp,
  output logic                 mul_start,
  input  logic                 mul_done,
  input  logic [NUM_WIDTH-1:0] prod,
  output logic [NUM_WIDTH-1:0] mx,
  output logic [NUM_WIDTH-1:0] my
);

  localparam int CW = $clog2(NUM_WIDTH + 1);

  typedef enum logic [2:0] {
    IDLE, SPLIT, SQ, MUL, CHECK, LOOP, DONE
  } state_t;

  state_t               state;
  logic [NUM_WIDTH-1:0] r;
  logic [NUM_WIDTH-1:0] y;
  logic [CW-1:0]        s;
  logic [CW-1:0]        bits;
  logic [CW-1:0]        j;
  logic [NUM_WIDTH-1:0] nm1;
  logic                 pend;

  // The multiplier is started once when pend is low; pend stays high while it runs.
  assign nm1       = n - 1'b1;
  assign mul_start = (state == SQ || state == MUL || state == LOOP) && !pend;
  assign mx        = (state == MUL) ? a : y;
  assign my        = y;

  always_ff @(posedge clk) begin
    fin <= 1'b0;
    if (rst) begin
      state <= IDLE;
      pend  <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (go) begin
            r     <= nm1;
            s     <= '0;
            y     <= NUM_WIDTH'(1);
            bits  <= CW'(NUM_WIDTH);
            state <= SPLIT;
          end
        end
        SPLIT: begin
          if (!r[0] && s != CW'(NUM_WIDTH)) begin
            r <= r >> 1;
            s <= s + 1'b1;
          end else begin
            state <= SQ;
            pend  <= 1'b0;
          end
        end
        SQ: begin
          pend <= 1'b1;
          if (mul_done && pend) begin
            y    <= prod;
            pend <= 1'b0;
            if (r[NUM_WIDTH-1]) begin
              state <= MUL;
            end else if (bits == CW'(1)) begin
              state <= CHECK;
            end else begin
              r    <= r << 1;
              bits <= bits - 1'b1;
            end
          end
        end
        MUL: begin
          pend <= 1'b1;
          if (mul_done && pend) begin
            y    <= prod;
            pend <= 1'b0;
            if (bits == CW'(1)) begin
              state <= CHECK;
            end else begin
              r     <= r << 1;
              bits  <= bits - 1'b1;
              state <= SQ;
            end
          end
        end
        CHECK: begin
          j <= CW'(1);
          if (y == NUM_WIDTH'(1) || y == nm1) begin
            comp  <= 1'b0;
            state <= DONE;
          end else if (s < CW'(2)) begin
            comp  <= 1'b1;
            state <= DONE;
          end else begin
            state <= LOOP;
          end
        end
        LOOP: begin
          pend <= 1'b1;
          if (mul_done && pend) begin
            y    <= prod;
            pend <= 1'b0;
            j    <= j + 1'b1;
            if (prod == NUM_WIDTH'(1)) begin
              comp  <= 1'b1;
              state <= DONE;
            end else if (prod == nm1) begin
              comp  <= 1'b0;
              state <= DONE;
            end else if (j + 1'b1 >= s) begin
              comp  <= 1'b1;
              state <= DONE;
            end
          end
        end
        DONE: begin
          fin   <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

@@ design/miller_rabin_witness_test.sv @@
// Channel | Direction | Payload
// in_ch   | sink      | candidate, base, last_round
// out_ch  | source    | round_composite, verdict_composite, bad_input, verdict_final
// A round uses the single bit-serial multiplier for up to 2*NUM_WIDTH modular
// multiplications for the power plus up to s-1 squarings. Bad input skips the
// multiplier: bad_done is registered on acceptance and loads the output register.
// Reset (rst, synchronous) clears the sticky flag and all control state.
// A new item is taken once the previous result has been accepted from the output register.
module miller_rabin_witness_test import mrwt_pkg::*; #(
  parameter int NUM_WIDTH = 32
) (
  input logic       clk,
  input logic       rst,
  mrwt_in_if.sink   in_ch,
  mrwt_out_if.source out_ch
);

  logic                 busy;
  logic                 go;
  logic                 fin;
  logic                 comp;
  logic                 last;
  logic                 composite_seen;
  logic [NUM_WIDTH-1:0] n;
  logic [NUM_WIDTH-1:0] a;
  logic [NUM_WIDTH-1:0] nin;
  logic [NUM_WIDTH-1:0] ain;
  logic                 bad;
  logic                 mul_start;
  logic                 mul_done;
  logic [NUM_WIDTH-1:0] prod;
  logic [NUM_WIDTH-1:0] mx;
  logic [NUM_WIDTH-1:0] my;
  logic                 bad_r;
  logic                 bad_done;

  assign nin = NUM_WIDTH'(in_ch.candidate);
  assign ain = NUM_WIDTH'(in_ch.base);
  assign in_ch.ready = !busy && !out_ch.valid;
  assign bad = (nin < NUM_WIDTH'(5)) || (ain < NUM_WIDTH'(2)) || (ain > nin - NUM_WIDTH'(2));

  mrwt_mulmod #(.NUM_WIDTH(NUM_WIDTH)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .x(mx), .y(my), .m(n),
    .done(mul_done), .p(prod)
  );

  mrwt_ctrl #(.NUM_WIDTH(NUM_WIDTH)) u_ctrl (
    .clk(clk), .rst(rst), .go(go), .n(n), .a(a), .fin(fin), .comp(comp),
    .mul_start(mul_start), .mul_done(mul_done), .prod(prod), .mx(mx), .my(my)
  );

  always_ff @(posedge clk) begin
    go       <= 1'b0;
    bad_done <= 1'b0;
    if (rst) begin
      busy           <= 1'b0;
      out_ch.valid   <= 1'b0;
      composite_seen <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        busy  <= 1'b1;
        n     <= nin;
        a     <= ain;
        last  <= in_ch.last_round;
        bad_r <= bad;
        if (bad) bad_done <= 1'b1;
        else go <= 1'b1;
      end
      if (fin || bad_done) begin
        busy                     <= 1'b0;
        out_ch.valid             <= 1'b1;
        out_ch.round_composite   <= bad_done | comp;
        out_ch.verdict_composite <= composite_seen | bad_done | comp;
        out_ch.bad_input         <= bad_r;
        out_ch.verdict_final     <= last;
        composite_seen           <= last ? 1'b0 : (composite_seen | bad_done | comp);
      end
    end
  end

endmodule

@@ design/mrwt_checker.sv @@
module mrwt_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic round_composite,
  input logic verdict_composite,
  input logic bad_input
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result item dropped");

  a_bad: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_input |-> round_composite) else $error("bad item not composite");

  a_verdict: assert property (@(posedge clk) disable iff (rst)
    out_valid && round_composite |-> verdict_composite) else $error("verdict lost round");

  a_noaccept: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("item taken while result waits");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second item taken while busy");

endmodule

bind miller_rabin_witness_test mrwt_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .round_composite(out_ch.round_composite),
  .verdict_composite(out_ch.verdict_composite), .bad_input(out_ch.bad_input)
);
